/* sv/slas_pkg.sv */
// shared types and constants for the serial line assembler
// used by slas_ctrl and serial_line_assembler; depends on nothing
`timescale 1ns / 1ps

package slas_pkg;

    // word kinds carried in s_tuser
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_RXERR = 2'd1;
    localparam logic [1:0] KIND_REARM = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic [7:0] ERR_MAX = 8'hff;

    // status reported with every result word
    typedef struct packed {
        logic       line_done;
        logic       event_pending;
        logic [6:0] line_length;
        logic [7:0] error_count;
        logic       accepting;
    } status_t;

endpackage

/* sv/slas_ctrl.sv */
// receive control: write position, accept flag, error count, event flag, fill mark
// depends on slas_pkg; drives the write port of slas_store
`timescale 1ns / 1ps

module slas_ctrl #(
    parameter int LINE_DEPTH = 64,
    parameter int AW         = $clog2(LINE_DEPTH),
    parameter int WPW        = $clog2(LINE_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [1:0]        kind,
    input  logic [7:0]        data_byte,
    output slas_pkg::status_t status_next,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [7:0]        wr_data,
    output logic [WPW-1:0]    fill_next
);

    localparam int LW = (WPW > 7) ? WPW : 7;

    logic [WPW-1:0] wp_reg, wp_next;
    logic           acc_reg, acc_next;
    logic [7:0]     rej_reg, rej_next;
    logic           evt_reg, evt_next;
    logic [WPW-1:0] fill_reg;
    logic           done;
    logic           can_store;
    logic           is_cr;
    logic           is_lf;
    logic [LW-1:0]  wp_wide;

    assign is_cr     = (data_byte == slas_pkg::CHAR_CR);
    assign is_lf     = (data_byte == slas_pkg::CHAR_LF);
    assign can_store = acc_reg && (rej_reg == 8'd0) && (wp_reg < WPW'(LINE_DEPTH));
    assign wr_addr   = wp_reg[AW-1:0];

    always_comb begin
        wp_next  = wp_reg;
        acc_next = acc_reg;
        rej_next = rej_reg;
        evt_next = evt_reg;
        done     = 1'b0;
        wr_en    = 1'b0;
        wr_data  = data_byte;
        case (kind)
            slas_pkg::KIND_BYTE: begin
                if (!is_lf) begin
                    if (can_store) begin
                        wr_en = 1'b1;
                        if (is_cr) begin
                            // terminator goes where the next byte would have gone
                            wr_data  = 8'd0;
                            acc_next = 1'b0;
                            done     = 1'b1;
                            evt_next = 1'b1;
                        end else begin
                            wp_next = WPW'(wp_reg + 1'b1);
                        end
                    end else begin
                        wp_next = '0;
                        if (is_cr) begin
                            rej_next = 8'd0;
                            acc_next = 1'b1;
                        end else if (rej_reg != slas_pkg::ERR_MAX) begin
                            rej_next = rej_reg + 8'd1;
                        end
                    end
                end
            end
            slas_pkg::KIND_REARM: begin
                wp_next  = '0;
                acc_next = 1'b1;
            end
            slas_pkg::KIND_CLEAR: begin
                evt_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // writes only ever land at the write position, so the written entries
    // are always a prefix of the store
    always_comb begin
        fill_next = fill_reg;
        if (wr_en && (wp_reg == fill_reg)) begin
            fill_next = WPW'(fill_reg + 1'b1);
        end
    end

    assign wp_wide = LW'(wp_next);

    always_comb begin
        status_next.line_done     = done;
        status_next.event_pending = evt_next;
        status_next.line_length   = wp_wide[6:0];
        status_next.error_count   = rej_next;
        status_next.accepting     = acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            acc_reg  <= 1'b1;
            rej_reg  <= 8'd0;
            evt_reg  <= 1'b0;
            fill_reg <= '0;
        end else if (step) begin
            wp_reg   <= wp_next;
            acc_reg  <= acc_next;
            rej_reg  <= rej_next;
            evt_reg  <= evt_next;
            fill_reg <= fill_next;
        end
    end

endmodule

/* sv/slas_store.sv */
// line store: one write port, one registered read port with same-word bypass
// depends on nothing; entries at or above the fill mark read as zero
`timescale 1ns / 1ps

module slas_store #(
    parameter int LINE_DEPTH = 64,
    parameter int AW         = $clog2(LINE_DEPTH),
    parameter int WPW        = $clog2(LINE_DEPTH + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           rd_en,
    input  logic [5:0]     rd_index,
    input  logic [WPW-1:0] fill,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  logic [7:0]     wr_data,
    output logic [7:0]     rd_data
);

    localparam int CW = (WPW > 6) ? WPW : 6;

    logic [7:0]    mem [LINE_DEPTH];
    logic [CW-1:0] ridx_w;
    logic          hit;
    logic [AW-1:0] rd_addr;
    logic          bypass;
    logic [7:0]    mem_q;
    logic          hit_reg;
    logic          bypass_reg;
    logic [7:0]    bdata_reg;

    assign ridx_w  = CW'(rd_index);
    // fill never exceeds the depth, so this also covers reads past the store
    assign hit     = ridx_w < CW'(fill);
    assign rd_addr = hit ? ridx_w[AW-1:0] : '0;
    assign bypass  = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q     <= mem[rd_addr];
            bdata_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg    <= 1'b0;
            bypass_reg <= 1'b0;
        end else if (rd_en) begin
            hit_reg    <= hit;
            bypass_reg <= bypass;
        end
    end

    assign rd_data = !hit_reg ? 8'd0 : (bypass_reg ? bdata_reg : mem_q);

endmodule

/* sv/serial_line_assembler.sv */
// serial line assembler top level: input register, control, line store, result register
// depends on slas_pkg, slas_ctrl and slas_store
`timescale 1ns / 1ps

// Usage:
//   s_ channel takes one word per received event: s_tuser carries the kind
//   (byte, byte with receive error, rearm, clear event), s_tdata the
//   character and the store position to report.
//   m_ channel returns exactly one word per input word: line status plus the
//   stored byte at the requested position; m_tlast marks the word whose
//   carriage return completed a line.
// Path: a word accepted on s_ passes through the input register, then the
//   result register, before its result is shown on m_.
// Throughput: one word per cycle while m_tready stays high; the control update and the
//   single write / single read of the store all fit in one stage.
// Reset: status returns to an empty, accepting line with no errors and no
//   event. The store takes no clearing pass: a fill mark tracks the written
//   prefix and positions at or above it read as zero, so the block is ready at once.
// Stall: when m_tready is low the result is held, the input register keeps
//   one more word, and s_tready then drops until the result is taken.

module serial_line_assembler #(
    parameter int LINE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], read_index[13:8], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // event_pending[0], line_length[7:1], error_count[15:8],
                                   // accepting[16], read_data[24:17], zero pad
    output logic        m_tlast    // line_done
);

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int WPW = $clog2(LINE_DEPTH + 1);

    logic              in_valid_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        byte_reg;
    logic [5:0]        ridx_reg;
    logic              out_valid_reg;
    slas_pkg::status_t status_reg;
    slas_pkg::status_t status_next;
    logic              advance;
    logic              step;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic [WPW-1:0]    fill_next;
    logic [7:0]        rd_data;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser;
            byte_reg <= s_tdata[7:0];
            ridx_reg <= s_tdata[13:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            status_reg <= status_next;
        end
    end

    slas_ctrl #(
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW),
        .WPW        (WPW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .kind        (kind_reg),
        .data_byte   (byte_reg),
        .status_next (status_next),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .fill_next   (fill_next)
    );

    // store writes and reads only when the word moves into the result register
    slas_store #(
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW),
        .WPW        (WPW)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (step),
        .rd_index (ridx_reg),
        .fill     (fill_next),
        .wr_en    (wr_en && step),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_data  (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = status_reg.line_done;
    assign m_tdata  = {7'd0, rd_data, status_reg.accepting, status_reg.error_count,
                       status_reg.line_length, status_reg.event_pending};

endmodule
